/* src/bmpf_pkg.sv */
// shared types and constants of the ble midi packet framer
`default_nettype none

package bmpf_pkg;

    // packet buffer depth, default for the top level parameter
    localparam int PACKET_BYTES_DEF = 20;

    // header and timestamp byte construction
    localparam logic [7:0] TS_MARK    = 8'h80;
    localparam logic [5:0] TS_HI_MASK = 6'h3F;
    localparam logic [6:0] TS_LO_MASK = 7'h7F;

    typedef enum logic [1:0] {
        OP_MESSAGE    = 2'd0,
        OP_FLUSH      = 2'd1,
        OP_CONNECT    = 2'd2,
        OP_DISCONNECT = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        SEL_HDR,
        SEL_TS,
        SEL_B0,
        SEL_B1,
        SEL_B2
    } t_wr_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD_START,
        ST_DRAIN,
        ST_WR_HDR,
        ST_WR_TS,
        ST_WR_B0,
        ST_WR_B1,
        ST_WR_B2
    } t_state;

    typedef struct packed {
        logic    capture;
        logic    set_link;
        logic    clr_link;
        logic    clr_fill;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    rd_start;
        logic    rd_next;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode     op;
        logic [1:0]  len;
        logic        link_up;
        logic        out_en;
        logic        fill_zero;
        logic        fill_ge3;
        logic        no_fit;
        logic        rd_last;
        logic        out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* src/bmpf_ctrl.sv */
// controller state machine of the ble midi packet framer
`default_nettype none

module bmpf_ctrl
    import bmpf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.wr_sel  = SEL_HDR;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                case (i_status.op)
                    OP_MESSAGE: begin
                        if (!i_status.link_up || !i_status.out_en || i_status.len == 2'd0) begin
                            n_state = ST_IDLE;
                        end else if (i_status.fill_zero || i_status.no_fit) begin
                            if (i_status.fill_ge3) begin
                                n_state = ST_RD_START;
                            end else begin
                                // short packet dropped before reopening
                                o_cmd.clr_fill = 1'b1;
                                n_state        = ST_WR_HDR;
                            end
                        end else begin
                            n_state = ST_WR_TS;
                        end
                    end
                    OP_FLUSH: begin
                        if (i_status.fill_ge3) begin
                            n_state = ST_RD_START;
                        end else begin
                            o_cmd.clr_fill = 1'b1;
                        end
                    end
                    OP_CONNECT: begin
                        o_cmd.set_link = 1'b1;
                    end
                    OP_DISCONNECT: begin
                        o_cmd.clr_link = 1'b1;
                        o_cmd.clr_fill = 1'b1;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RD_START: begin
                o_cmd.rd_start = 1'b1;
                n_state        = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.rd_next = 1'b1;
                    if (i_status.rd_last) begin
                        o_cmd.clr_fill = 1'b1;
                        n_state = (i_status.op == OP_MESSAGE) ? ST_WR_HDR : ST_IDLE;
                    end
                end
            end
            ST_WR_HDR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = SEL_HDR;
                n_state      = ST_WR_TS;
            end
            ST_WR_TS: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = SEL_TS;
                n_state      = ST_WR_B0;
            end
            ST_WR_B0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = SEL_B0;
                n_state      = (i_status.len >= 2'd2) ? ST_WR_B1 : ST_IDLE;
            end
            ST_WR_B1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = SEL_B1;
                n_state      = (i_status.len == 2'd3) ? ST_WR_B2 : ST_IDLE;
            end
            ST_WR_B2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = SEL_B2;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/bmpf_dp.sv */
// datapath of the ble midi packet framer: item register, packet buffer, output register
`default_nettype none

module bmpf_dp
    import bmpf_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [39:0] s_axis_tdata,
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  wire         i_cfg_wen,
    input  wire         i_cfg_wdata,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status
);

    localparam int FW = $clog2(PACKET_BYTES + 1);
    localparam int AW = $clog2(PACKET_BYTES);
    localparam int SW = FW + 1;

    // latched item
    t_opcode     r_op;
    logic [1:0]  r_len;
    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;
    logic [12:0] r_time;

    logic          r_link_up;
    logic          r_out_en;
    logic [FW-1:0] r_fill;
    logic [AW-1:0] r_rd_idx;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [PACKET_BYTES];

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0]    wr_byte;
    logic [SW-1:0] need;
    logic          rd_last;
    logic          out_free;
    logic          wr_ok;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_opcode'(s_axis_tuser);
            r_len  <= s_axis_tdata[1:0];
            r_b0   <= s_axis_tdata[9:2];
            r_b1   <= s_axis_tdata[17:10];
            r_b2   <= s_axis_tdata[25:18];
            r_time <= s_axis_tdata[38:26];
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            SEL_HDR: wr_byte = TS_MARK | {2'b00, r_time[12:7] & TS_HI_MASK};
            SEL_TS:  wr_byte = TS_MARK | {1'b0, r_time[6:0] & TS_LO_MASK};
            SEL_B0:  wr_byte = r_b0;
            SEL_B1:  wr_byte = r_b1;
            SEL_B2:  wr_byte = r_b2;
            default: wr_byte = r_b0;
        endcase
    end

    assign need     = SW'(r_fill) + SW'(r_len) + SW'(1);
    assign rd_last  = (r_rd_idx == AW'(r_fill - FW'(1)));
    assign out_free = !r_out_valid || m_axis_tready;
    assign wr_ok    = i_cmd.wr_en && (r_fill < FW'(PACKET_BYTES));
    assign rd_addr  = i_cmd.rd_start ? '0 : AW'(r_rd_idx + AW'(1));
    assign rd_en    = i_cmd.rd_start || (i_cmd.rd_next && !rd_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up <= 1'b0;
            r_out_en  <= 1'b1;
            r_fill    <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_out_en <= i_cfg_wdata;
            end
            if (i_cmd.set_link) begin
                r_link_up <= 1'b1;
            end else if (i_cmd.clr_link) begin
                r_link_up <= 1'b0;
            end
            if (i_cmd.clr_fill) begin
                r_fill <= '0;
            end else if (wr_ok) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    // packet buffer, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_fill[AW-1:0]] <= wr_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= AW'(r_rd_idx + AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rd_next) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_next) begin
            r_out_byte <= r_rd_data;
            r_out_last <= rd_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        o_status.op        = r_op;
        o_status.len       = r_len;
        o_status.link_up   = r_link_up;
        o_status.out_en    = r_out_en;
        o_status.fill_zero = (r_fill == '0);
        o_status.fill_ge3  = (r_fill >= FW'(3));
        o_status.no_fit    = (need > SW'(PACKET_BYTES));
        o_status.rd_last   = rd_last;
        o_status.out_free  = out_free;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(PACKET_BYTES))
        else $error("fill count beyond packet buffer");

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> r_fill < FW'(PACKET_BYTES))
        else $error("byte write into a full packet buffer");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_next |-> out_free)
        else $error("output register overwritten while still held");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_next && rd_last) |=> (r_fill == '0) && m_axis_tlast)
        else $error("buffer not emptied after last beat of a packet");

endmodule

`default_nettype wire

/* src/ble_midi_packet_framer_top.sv */
// top level of the ble midi packet framer
// Packs MIDI messages of 1 to 3 bytes into BLE-MIDI packets of up to
// PACKET_BYTES bytes. One input beat carries a command in s_axis_tuser: a
// message, a flush, a connect or a disconnect. A message opens a packet with a
// header byte when the buffer is empty or would overflow (a buffered packet is
// sent first in that case if it holds 3 or more bytes, else dropped), then adds a
// timestamp-low byte and its own bytes. A flush sends the buffered packet as a
// run of beats ending in tlast, or drops it when it holds fewer than 3 bytes.
// Messages are ignored while not connected or while output_enable is 0; a
// disconnect empties the buffer silently. An item is accepted in ST_IDLE and
// decided in ST_EVAL, then a message writes its 2 to 5 bytes at one per cycle
// into the single-port write side of the packet buffer. Sending a packet takes
// a read setup step, then one beat per cycle from the buffer's registered read
// port while m_axis_tready is high or the output register is empty.
// The block takes one item at a time; a finished beat can wait in the output
// register while the next item is accepted.
`default_nettype none

module ble_midi_packet_framer_top
    import bmpf_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] message_length, [9:2] message_byte_first, [17:10] message_byte_second,
    // [25:18] message_byte_third, [38:26] time_millis, [39] zero
    input  wire  [39:0] s_axis_tdata,
    // [1:0] opcode
    input  wire  [1:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] packet_byte
    output logic [7:0]  m_axis_tdata,
    // packet_last
    output logic        m_axis_tlast,
    // output_enable register write
    input  wire         i_cfg_wen,
    input  wire         i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // state machine: accept, decide, drain, byte writes
    bmpf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // item register, link and enable flags, packet buffer and output beat
    bmpf_dp #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

`default_nettype wire
